// ----- design/sidt_pkg.sv -----
// Package for the sorted insert/delete table.
// Request kinds, status codes and the per-cell control struct.
// No dependencies.
package sidt_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int POS_W = 4;
	localparam int OUT_CNT_W = 5;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic ins;     // insert commits this cycle
		logic del;     // delete commits this cycle
		logic below;   // cell index below stored count
		logic at_cnt;  // cell index equals stored count
		logic ge_pos;  // cell index at or above delete position
	} cell_ctrl_t;

endpackage

// ----- design/sorted_insert_delete_table.sv -----
// Top level of the sorted insert/delete table: a row of CAPACITY cells.
// Depends on sidt_pkg and sidt_cell.
//
// Keeps up to CAPACITY entries in ascending signed key order; equal keys keep
// arrival order. Every transaction (insert, delete by position, read by
// position) is applied in the cell row and yields one result, so
// a new transaction is taken every cycle as long as the result register is
// free or being drained. Entries above the count hold stale data; there is no
// clearing pass after reset. Only positions 0 to 15 are addressable.
module sorted_insert_delete_table #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic signed [sidt_pkg::KEY_W-1:0]   entry_key,
	input  logic        [sidt_pkg::PAY_W-1:0]   entry_payload,
	input  logic [sidt_pkg::POS_W-1:0]          position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [sidt_pkg::OUT_CNT_W-1:0]      entry_count,
	output logic signed [sidt_pkg::KEY_W-1:0]   read_key,
	output logic        [sidt_pkg::PAY_W-1:0]   read_payload
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > sidt_pkg::POS_W) ? CW : sidt_pkg::POS_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          accept;
	logic          full;
	logic          pos_ok;
	logic          do_ins;
	logic          do_del;
	logic          do_read;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [1:0]    status_next;

	logic signed [sidt_pkg::KEY_W-1:0] cell_key     [CAPACITY];
	logic        [sidt_pkg::PAY_W-1:0] cell_payload [CAPACITY];
	logic                              cell_hit     [CAPACITY];
	sidt_pkg::cell_ctrl_t              cell_ctrl    [CAPACITY];

	logic signed [sidt_pkg::KEY_W-1:0] rd_key;
	logic        [sidt_pkg::PAY_W-1:0] rd_payload;

	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic [sidt_pkg::OUT_CNT_W-1:0]    entry_count_q;
	logic signed [sidt_pkg::KEY_W-1:0] read_key_q;
	logic        [sidt_pkg::PAY_W-1:0] read_payload_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign pos_ext = PW'(position);
	assign cnt_ext = PW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign pos_ok  = (pos_ext < cnt_ext);

	assign do_ins  = accept && (kind == sidt_pkg::KIND_INSERT) && !full;
	assign do_del  = accept && (kind == sidt_pkg::KIND_DELETE) && pos_ok;
	assign do_read = (kind == sidt_pkg::KIND_READ) && pos_ok;

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CW'(1);
		end else if (do_del) begin
			count_next = count_q - CW'(1);
		end
	end

	always_comb begin
		status_next = sidt_pkg::ST_DONE;
		unique case (kind) inside
			sidt_pkg::KIND_INSERT: begin
				if (full) status_next = sidt_pkg::ST_FULL;
			end
			sidt_pkg::KIND_DELETE, sidt_pkg::KIND_READ: begin
				if (!pos_ok) status_next = sidt_pkg::ST_RANGE;
			end
			default: status_next = sidt_pkg::ST_DONE;
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_ctrl[i].ins    = do_ins;
			cell_ctrl[i].del    = do_del;
			cell_ctrl[i].below  = (CW'(i) < count_q);
			cell_ctrl[i].at_cnt = (CW'(i) == count_q);
			cell_ctrl[i].ge_pos = (PW'(i) >= pos_ext);
		end
	end

	// read select over the addressable cells
	always_comb begin
		rd_key     = '0;
		rd_payload = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_read && (PW'(i) == pos_ext)) begin
				rd_key     = cell_key[i];
				rd_payload = cell_payload[i];
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                              hl;
		logic signed [sidt_pkg::KEY_W-1:0] lk;
		logic        [sidt_pkg::PAY_W-1:0] lp;
		logic signed [sidt_pkg::KEY_W-1:0] rk;
		logic        [sidt_pkg::PAY_W-1:0] rp;

		if (g == 0) begin : g_first
			assign hl = 1'b0;
			assign lk = cell_key[g];
			assign lp = cell_payload[g];
		end else begin : g_mid
			assign hl = cell_hit[g-1];
			assign lk = cell_key[g-1];
			assign lp = cell_payload[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign rk = cell_key[g];
			assign rp = cell_payload[g];
		end else begin : g_inner
			assign rk = cell_key[g+1];
			assign rp = cell_payload[g+1];
		end

		sidt_cell u_cell (
			.clk           (clk),
			.ctrl          (cell_ctrl[g]),
			.new_key       (entry_key),
			.new_payload   (entry_payload),
			.hit_left      (hl),
			.left_key      (lk),
			.left_payload  (lp),
			.right_key     (rk),
			.right_payload (rp),
			.hit           (cell_hit[g]),
			.cell_key      (cell_key[g]),
			.cell_payload  (cell_payload[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_next;
			entry_count_q  <= sidt_pkg::OUT_CNT_W'(count_next);
			read_key_q     <= rd_key;
			read_payload_q <= rd_payload;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign read_key     = read_key_q;
	assign read_payload = read_payload_q;

endmodule

// ----- design/sidt_cell.sv -----
// One cell of the sorted table: holds one key and payload.
// Shifts up from its left neighbor on insert, down from its right on delete.
// Depends on sidt_pkg.
module sidt_cell (
	input  logic                                clk,
	input  sidt_pkg::cell_ctrl_t                ctrl,
	input  logic signed [sidt_pkg::KEY_W-1:0]   new_key,
	input  logic        [sidt_pkg::PAY_W-1:0]   new_payload,
	input  logic                                hit_left,
	input  logic signed [sidt_pkg::KEY_W-1:0]   left_key,
	input  logic        [sidt_pkg::PAY_W-1:0]   left_payload,
	input  logic signed [sidt_pkg::KEY_W-1:0]   right_key,
	input  logic        [sidt_pkg::PAY_W-1:0]   right_payload,
	output logic                                hit,
	output logic signed [sidt_pkg::KEY_W-1:0]   cell_key,
	output logic        [sidt_pkg::PAY_W-1:0]   cell_payload
);

	logic signed [sidt_pkg::KEY_W-1:0] key_q;
	logic        [sidt_pkg::PAY_W-1:0] payload_q;

	// insert point: first stored key strictly greater, or the first free cell
	assign hit = ctrl.below ? (key_q > new_key) : ctrl.at_cnt;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (hit_left) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else if (hit) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (ctrl.del && ctrl.ge_pos) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	assign cell_key     = key_q;
	assign cell_payload = payload_q;

endmodule

// ----- sim/sorted_insert_delete_table_tb.sv -----
// Testbench for sorted_insert_delete_table: drives insert, delete and read
// transactions and checks each result against a scoreboard's table copy.
// Depends on sidt_pkg and the sorted_insert_delete_table RTL.
module sorted_insert_delete_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 700;
	localparam int SEGMENT_LEN = 40;
	localparam int LONG_HOLD = 48;
	localparam int STALL_LIMIT = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_CAP = 40;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [sidt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [sidt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct packed {
		logic [1:0]                           status;
		logic [sidt_pkg::OUT_CNT_W-1:0]       entry_count;
		logic signed [sidt_pkg::KEY_W-1:0]    read_key;
		logic [sidt_pkg::PAY_W-1:0]           read_payload;
	} table_result_t;

	class table_scoreboard;
		logic signed [sidt_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
		logic [sidt_pkg::PAY_W-1:0] payloads [TABLE_DEPTH];
		int filled;
		table_result_t awaited [$];
		int mismatches;
		int reported;

		function new();
			filled = 0;
			mismatches = 0;
			reported = 0;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void note_request(logic [1:0] k, logic signed [sidt_pkg::KEY_W-1:0] key,
				logic [sidt_pkg::PAY_W-1:0] pay, logic [sidt_pkg::POS_W-1:0] pos);
			table_result_t want;
			int slot;
			want = '0;
			want.status = sidt_pkg::ST_DONE;
			case (k)
				sidt_pkg::KIND_INSERT: begin
					if (filled >= TABLE_DEPTH) begin
						want.status = sidt_pkg::ST_FULL;
					end else begin
						slot = filled;
						for (int i = 0; i < filled; i++) begin
							if (keys[i] > key) begin
								slot = i;
								break;
							end
						end
						for (int i = filled; i > slot; i--) begin
							keys[i] = keys[i-1];
							payloads[i] = payloads[i-1];
						end
						keys[slot] = key;
						payloads[slot] = pay;
						filled++;
					end
				end
				sidt_pkg::KIND_DELETE: begin
					if (int'(pos) >= filled) begin
						want.status = sidt_pkg::ST_RANGE;
					end else begin
						for (int i = int'(pos); i + 1 < filled; i++) begin
							keys[i] = keys[i+1];
							payloads[i] = payloads[i+1];
						end
						filled--;
					end
				end
				sidt_pkg::KIND_READ: begin
					if (int'(pos) >= filled) begin
						want.status = sidt_pkg::ST_RANGE;
					end else begin
						want.read_key = keys[pos];
						want.read_payload = payloads[pos];
					end
				end
				default: ;
			endcase
			want.entry_count = sidt_pkg::OUT_CNT_W'(filled);
			awaited.push_back(want);
		endfunction

		function void report_field(string field, longint want, longint got);
			if (want != got) begin
				mismatches++;
				if (reported < REPORT_CAP)
					$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, field, want, got);
				reported++;
			end
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (reported < REPORT_CAP)
					$display("%0t: result with nothing pending, expected none, actual status %0d",
						$time, got.status);
				reported++;
				return;
			end
			want = awaited.pop_front();
			report_field("status", want.status, got.status);
			report_field("entry_count", want.entry_count, got.entry_count);
			report_field("read_key", want.read_key, got.read_key);
			report_field("read_payload", want.read_payload, got.read_payload);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = sidt_pkg::KIND_INSERT;
	logic signed [sidt_pkg::KEY_W-1:0] entry_key = '0;
	logic [sidt_pkg::PAY_W-1:0] entry_payload = '0;
	logic [sidt_pkg::POS_W-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [sidt_pkg::OUT_CNT_W-1:0] entry_count;
	logic signed [sidt_pkg::KEY_W-1:0] read_key;
	logic [sidt_pkg::PAY_W-1:0] read_payload;

	table_scoreboard sb;
	int fill_level = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit quiet_tail = 1'b0;
	int stalled_cycles = 0;

	sorted_insert_delete_table #(.CAPACITY(TABLE_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.entry_key(entry_key),
		.entry_payload(entry_payload),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.read_key(read_key),
		.read_payload(read_payload)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic offer_request(input logic [1:0] req_kind,
			input logic signed [sidt_pkg::KEY_W-1:0] req_key,
			input logic [sidt_pkg::PAY_W-1:0] req_payload,
			input logic [sidt_pkg::POS_W-1:0] req_pos);
		in_valid <= 1'b1;
		kind <= req_kind;
		entry_key <= req_key;
		entry_payload <= req_payload;
		position <= req_pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (req_kind == sidt_pkg::KIND_INSERT && fill_level < TABLE_DEPTH)
			fill_level++;
		else if (req_kind == sidt_pkg::KIND_DELETE && int'(req_pos) < fill_level)
			fill_level--;
	endtask

	task automatic idle_gap(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic signed [sidt_pkg::KEY_W-1:0] random_key();
		case ($urandom_range(0, 9)) inside
			0: return KEY_MAX;
			1: return KEY_MIN;
			[2:5]: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	// transaction monitor and scoreboard hookup
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{status, entry_count, read_key, read_payload});
			if (in_valid && in_ready)
				sb.note_request(kind, entry_key, entry_payload, position);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 99) < recv_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int counted;
		int next_segment;
		int segment;
		int r;
		mix_t mix;
		logic [1:0] k;
		logic [sidt_pkg::POS_W-1:0] pos;

		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 20;
		recv_stall_pct = 20;

		// empty table, ignored kind, extremes and equal keys
		offer_request(sidt_pkg::KIND_READ, $urandom, $urandom, 4'd0);
		offer_request(sidt_pkg::KIND_DELETE, $urandom, $urandom, 4'd0);
		offer_request(KIND_UNUSED, -32'sd1, '1, 4'd15);
		offer_request(sidt_pkg::KIND_INSERT, KEY_MAX, '0, 4'd0);
		offer_request(sidt_pkg::KIND_INSERT, KEY_MIN, '1, 4'd15);
		offer_request(sidt_pkg::KIND_INSERT, '0, 32'hA5A5_A5A5, 4'd0);
		offer_request(sidt_pkg::KIND_INSERT, '0, 32'h5A5A_5A5A, 4'd0);
		offer_request(sidt_pkg::KIND_INSERT, -32'sd1, 32'h1, 4'd0);
		offer_request(sidt_pkg::KIND_READ, '0, '0, 4'd2);
		offer_request(sidt_pkg::KIND_READ, '0, '0, 4'd3);
		offer_request(sidt_pkg::KIND_READ, '0, '0, 4'd15);
		for (int i = 0; i < 11; i++)
			offer_request(sidt_pkg::KIND_INSERT, random_key(), $urandom, 4'd0);
		offer_request(sidt_pkg::KIND_INSERT, 32'sd5, 32'd5, 4'd0);
		offer_request(sidt_pkg::KIND_READ, '1, '1, 4'd15);
		offer_request(sidt_pkg::KIND_DELETE, '0, '0, 4'd15);
		offer_request(sidt_pkg::KIND_DELETE, '0, '0, 4'd0);
		offer_request(sidt_pkg::KIND_DELETE, '0, '0, 4'd14);

		counted = 0;
		next_segment = 0;
		segment = 0;
		mix = MIX_FILL;
		while (counted < RANDOM_ITEMS) begin
			if (counted >= next_segment) begin
				next_segment += SEGMENT_LEN;
				mix = mix_t'($urandom_range(0, 2));
				send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
				recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
				if (segment == 6) begin
					// back-to-back offers against a stalled result side
					mix = MIX_FILL;
					send_gap_pct = 0;
					hold_req = 1'b1;
				end else if (segment == 11) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.outstanding() != 0) @(posedge clk);
				end
				if (counted >= RANDOM_ITEMS - 100) begin
					quiet_tail = 1'b1;
					send_gap_pct = 0;
				end
				segment++;
			end
			r = $urandom_range(0, 99);
			if (r < 2)
				k = KIND_UNUSED;
			else if (mix == MIX_FILL)
				k = (r < 72) ? sidt_pkg::KIND_INSERT :
					(r < 86) ? sidt_pkg::KIND_DELETE : sidt_pkg::KIND_READ;
			else if (mix == MIX_DRAIN)
				k = (r < 20) ? sidt_pkg::KIND_INSERT :
					(r < 75) ? sidt_pkg::KIND_DELETE : sidt_pkg::KIND_READ;
			else
				k = (r < 40) ? sidt_pkg::KIND_INSERT :
					(r < 70) ? sidt_pkg::KIND_DELETE : sidt_pkg::KIND_READ;
			if (fill_level > 0 && $urandom_range(0, 4) != 0)
				pos = sidt_pkg::POS_W'($urandom_range(0, fill_level - 1));
			else
				pos = sidt_pkg::POS_W'($urandom_range(0, 15));
			offer_request(k, random_key(), $urandom, pos);
			if (k != KIND_UNUSED)
				counted++;
			if ($urandom_range(0, 99) < send_gap_pct)
				idle_gap($urandom_range(1, 8));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sidt_pkg.sv
design/sidt_cell.sv
design/sorted_insert_delete_table.sv
sim/sorted_insert_delete_table_tb.sv
